/* hdl/tape_edge_to_sample_runs_unit_assert.svh */
// assertion macros for the tape edge to sample runs unit
`ifndef TAPE_EDGE_TO_SAMPLE_RUNS_UNIT_ASSERT_SVH
`define TAPE_EDGE_TO_SAMPLE_RUNS_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define TESR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define TESR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tesr_pkg.sv */
// shared constants and types of the tape edge to sample runs unit
package tesr_pkg;

	localparam int BALANCE_BITS_DEF = 40;
	localparam int TICKS_BITS       = 32;
	localparam int DIVISOR_BITS     = 16;
	localparam int COUNT_BITS       = 40;
	localparam int SAMPLE_BITS      = 8;

	localparam logic [DIVISOR_BITS-1:0] TICKS_RESET = 16'd85;
	localparam logic [SAMPLE_BITS-1:0]  HIGH_SAMPLE = 8'hff;
	localparam logic [SAMPLE_BITS-1:0]  LOW_SAMPLE  = 8'h00;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

/* hdl/tesr_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
module tesr_divider #(
	parameter int DVD_BITS = tesr_pkg::BALANCE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [DVD_BITS-1:0]               dividend,
	input  logic [tesr_pkg::DIVISOR_BITS-1:0] divisor,
	output logic [DVD_BITS-1:0]               quotient,
	output logic [tesr_pkg::DIVISOR_BITS-1:0] remainder,
	output tesr_pkg::div_sts_t                status
);

	localparam int DsrW = tesr_pkg::DIVISOR_BITS;
	localparam int CntW = $clog2(DVD_BITS + 1);

	logic [DVD_BITS-1:0] dvd_q;
	logic [DsrW-1:0]     rem_q;
	logic [DsrW-1:0]     dsr_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DsrW:0] part;
	logic [DsrW:0] diff;
	logic          ge;

	// shift in the next dividend bit and try the subtract
	assign part = {rem_q, dvd_q[DVD_BITS-1]};
	assign diff = part - {1'b0, dsr_q};
	assign ge   = (part >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? diff[DsrW-1:0] : part[DsrW-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

/* hdl/tape_edge_to_sample_runs_unit.sv */
// top level of the tape edge to sample runs unit
//
// channel  | dir | transaction carries
// ---------+-----+-----------------------------------------------------------
// s_*      | in  | one tape edge: ticks in tdata, flags in tuser, tape end in tlast
// m_*      | out | one run: sample count and sample byte in tdata, last run in tlast
// cfg_*    | in  | write of ticks_per_sample
//
// an edge event runs in steps: the sequencer takes the transaction and adds its ticks,
// the bit-serial divider works through the balance, the sequencer sees it finish, and the
// rounding step rounds and loads the output register; a no-edge event is only taken and added
// reset clears level, balance, sequencer and output valid; ticks_per_sample goes to 85
// the output register holds a run while m_tready is low and the next event is
// still taken; the sequencer waits in its last step only if that register is full
module tape_edge_to_sample_runs_unit #(
	parameter int BALANCE_BITS = tesr_pkg::BALANCE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// edge event input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] pulse_ticks
	input  logic [3:0]  s_tuser,  // [0] no_edge, [1] force_low, [2] force_high, [3] stop_mark
	input  logic        s_tlast,  // tape_end
	// run output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [39:0] sample_count, [47:40] sample_value
	output logic        m_tlast,  // last_run
	// ticks_per_sample write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	`include "tape_edge_to_sample_runs_unit_assert.svh"

	localparam int DsrW   = tesr_pkg::DIVISOR_BITS;
	localparam int TickW  = tesr_pkg::TICKS_BITS;
	localparam int CountW = tesr_pkg::COUNT_BITS;
	localparam int SampW  = tesr_pkg::SAMPLE_BITS;
	localparam int CntW   = BALANCE_BITS + 1;

	// tuser flag positions
	localparam int UNoEdge    = 0;
	localparam int UForceLow  = 1;
	localparam int UForceHigh = 2;
	localparam int UStopMark  = 3;

	tesr_pkg::state_t   state_q, state_n;
	tesr_pkg::div_sts_t div_sts;

	logic [DsrW-1:0]         tps_q;      // ticks per sample
	logic                    level_q;    // signal level
	logic [BALANCE_BITS-1:0] balance_q;  // running tick balance
	logic                    tape_end_q;

	logic                    m_tvalid_q;
	logic [CountW-1:0]       m_count_q;
	logic [SampW-1:0]        m_value_q;
	logic                    m_last_q;

	logic                    in_accept;
	logic                    no_edge;
	logic                    div_start;
	logic                    out_free;
	logic                    out_load;
	logic                    level_n;
	logic [DsrW-1:0]         eff_div;
	logic [BALANCE_BITS:0]   sum_wide;
	logic [BALANCE_BITS-1:0] sum_sat;
	logic [BALANCE_BITS-1:0] quotient;
	logic [DsrW-1:0]         remainder;
	logic                    round_up;
	logic [CntW-1:0]         count_wide;
	logic [CountW-1:0]       count_sat;

	assign in_accept = s_tvalid && s_tready;
	assign no_edge   = s_tuser[UNoEdge];
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// a zero divisor counts as one
	assign eff_div = (tps_q == '0) ? DsrW'(1) : tps_q;

	// saturating add of the event's ticks into the balance
	assign sum_wide = {1'b0, balance_q} + (BALANCE_BITS + 1)'(s_tdata[TickW-1:0]);
	assign sum_sat  = sum_wide[BALANCE_BITS] ? '1 : sum_wide[BALANCE_BITS-1:0];

	// level update: forces win over toggle, low over high, no-edge holds, as do zero ticks with no flag
	always_comb begin
		level_n = level_q;
		if ((s_tdata != '0) || s_tuser[UStopMark] || s_tuser[UForceLow]
				|| s_tuser[UForceHigh]) begin
			if (no_edge) begin
				level_n = level_q;
			end else if (s_tuser[UForceLow]) begin
				level_n = 1'b0;
			end else if (s_tuser[UForceHigh]) begin
				level_n = 1'b1;
			end else begin
				level_n = ~level_q;
			end
		end
	end

	tesr_divider #(
		.DVD_BITS(BALANCE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_sat),
		.divisor  (eff_div),
		.quotient (quotient),
		.remainder(remainder),
		.status   (div_sts)
	);

	// remainder above half the divisor rounds the run up and empties the balance
	assign round_up   = (remainder > (eff_div >> 1));
	assign count_wide = {1'b0, quotient} + CntW'(round_up);

	generate
		if (CntW > CountW) begin : g_sat
			assign count_sat = (|count_wide[CntW-1:CountW]) ? '1 : count_wide[CountW-1:0];
		end else begin : g_ext
			assign count_sat = CountW'(count_wide);
		end
	endgenerate

	// sequencer next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			tesr_pkg::ST_IDLE: begin
				if (in_accept && !no_edge) begin
					state_n = tesr_pkg::ST_DIV;
				end
			end
			tesr_pkg::ST_DIV: begin
				if (div_sts.done) begin
					state_n = tesr_pkg::ST_DONE;
				end
			end
			tesr_pkg::ST_DONE: begin
				if (out_free) begin
					state_n = tesr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = tesr_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tesr_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && !no_edge;
			end
			tesr_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tesr_pkg::ST_IDLE;
			tps_q      <= tesr_pkg::TICKS_RESET;
			level_q    <= 1'b0;
			balance_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
			if (in_accept) begin
				level_q   <= level_n;
				balance_q <= sum_sat;
			end else if (out_load) begin
				balance_q <= round_up ? '0 : BALANCE_BITS'(remainder);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// run payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tape_end_q <= s_tlast;
		end
		if (out_load) begin
			m_count_q <= count_sat;
			m_value_q <= level_q ? tesr_pkg::HIGH_SAMPLE : tesr_pkg::LOW_SAMPLE;
			m_last_q  <= tape_end_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_value_q, m_count_q};
	assign m_tlast  = m_last_q;

	// an edge event always starts a division
	`TESR_ASSERT_NEXT(a_edge_starts_div, clk, arst_n, in_accept && !no_edge, state_q == tesr_pkg::ST_DIV && div_sts.busy, "edge event did not start the divider")
	// the divider finishes only while the sequencer waits for it
	`TESR_ASSERT(a_done_in_div, clk, arst_n, div_sts.done |-> state_q == tesr_pkg::ST_DIV, "divider finished outside the divide step")
	// after a run the balance is below the divisor
	`TESR_ASSERT_NEXT(a_balance_reduced, clk, arst_n, out_load, balance_q < BALANCE_BITS'(eff_div), "balance not reduced below divisor after a run")
	// a run appears only from the rounding step
	`TESR_ASSERT(a_out_from_done, clk, arst_n, $rose(m_tvalid_q) |-> $past(state_q) == tesr_pkg::ST_DONE, "run loaded outside the rounding step")

endmodule
